// ----- src/assert_macros.svh -----
// assertion helper macros for the rate table checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- src/wert_pkg.sv -----
// ----------------------------------------------------------------------------
// wert_pkg
// types and constants shared by the windowed event rate table
// ----------------------------------------------------------------------------
`default_nettype none

package wert_pkg;

    localparam int ENTRIES    = 32;
    localparam int BUCKETS    = 10;
    localparam int KEY_BITS   = 16;
    localparam int COUNT_BITS = 16;
    localparam int IDX_BITS   = 5;
    localparam int BKT_BITS   = 4;
    localparam int ADDR_BITS  = 9;
    localparam int USED_BITS  = 6;
    localparam int TOTAL_BITS = 20;

    // reciprocal of the bucket count: floor(x / BUCKETS) = (x * BKT_RECIP) >> BKT_RECIP_SHIFT
    localparam logic [31:0] BKT_RECIP       = 32'hCCCCCCCD;
    localparam int          BKT_RECIP_SHIFT = 35;

    localparam logic [1:0] CMD_COUNT = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [2:0] ST_COUNTED = 3'd0;
    localparam logic [2:0] ST_ADDED   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_READ_OK = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] key;
        logic [31:0] now;
        logic [4:0]  read_index;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  entry_index;
        logic [15:0] key_out;
        logic [19:0] window_total;
    } out_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_SEARCH_WAIT,
        S_CLEAN_RD,
        S_CLEAN_WAIT,
        S_CLEAN,
        S_BUMP_RD,
        S_BUMP_WAIT,
        S_BUMP,
        S_INIT,
        S_SUM,
        S_SUM_WAIT,
        S_DONE
    } state_t;

    // bucket store port group
    typedef struct packed {
        logic                  we;
        logic [ADDR_BITS-1:0]  waddr;
        logic [COUNT_BITS-1:0] wdata;
        logic [ADDR_BITS-1:0]  raddr;
    } bkt_req_t;

    // entry store port group (key and stamp side by side)
    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        logic [KEY_BITS-1:0] wkey;
        logic [31:0]         wstamp;
        logic                wkey_en;
        logic [IDX_BITS-1:0] raddr;
    } ent_req_t;

endpackage

`default_nettype wire

// ----- src/wert_bucket_ram.sv -----
// ----------------------------------------------------------------------------
// wert_bucket_ram
// bucket count store, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module wert_bucket_ram
    import wert_pkg::*;
(
    input  wire logic                  clk,
    input  wire bkt_req_t              req,
    output logic [COUNT_BITS-1:0]      rdata
);

    logic [COUNT_BITS-1:0] mem [ENTRIES*BUCKETS];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[req.raddr];
    end

endmodule

`default_nettype wire

// ----- src/wert_entry_ram.sv -----
// ----------------------------------------------------------------------------
// wert_entry_ram
// per-entry key and cleanup stamp store with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module wert_entry_ram
    import wert_pkg::*;
(
    input  wire logic                clk,
    input  wire ent_req_t            req,
    output logic [KEY_BITS-1:0]      rkey,
    output logic [31:0]              rstamp
);

    logic [KEY_BITS-1:0] key_mem   [ENTRIES];
    logic [31:0]         stamp_mem [ENTRIES];

    // write port
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            stamp_mem[req.waddr] <= req.wstamp;
            if (req.wkey_en)
            begin
                key_mem[req.waddr] <= req.wkey;
            end
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rkey   <= key_mem[req.raddr];
        rstamp <= stamp_mem[req.raddr];
    end

endmodule

`default_nettype wire

// ----- src/wert_ctrl.sv -----
// ----------------------------------------------------------------------------
// wert_ctrl
// sequencer: key search, new entry init, lazy bucket clearing, bump, tick walk and read sum
// ----------------------------------------------------------------------------
`default_nettype none

module wert_ctrl
    import wert_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_data,
    output bkt_req_t                   bkt,
    input  wire logic [COUNT_BITS-1:0] bkt_rdata,
    output ent_req_t                   ent,
    input  wire logic [KEY_BITS-1:0]   ent_rkey,
    input  wire logic [31:0]           ent_rstamp
);

    state_t                state_reg, state_next;
    in_item_t              item_reg;
    logic [USED_BITS-1:0]  used_reg, used_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;     // entry under work
    logic [USED_BITS-1:0]  scan_reg, scan_next;   // search / tick position
    logic [BKT_BITS-1:0]   bk_reg, bk_next;       // bucket position
    logic [BKT_BITS-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [BKT_BITS-1:0]   clr_pos_reg, clr_pos_next;
    logic [TOTAL_BITS:0]   sum_reg, sum_next;
    logic                  tick_mode_reg, tick_mode_next;
    out_item_t             out_reg, out_next;
    logic                  out_valid_reg, out_valid_next;

    // now mod buckets and clear span, from the held item and the read stamp
    logic [BKT_BITS-1:0]   now_bkt;
    logic [32:0]           span;
    logic [ADDR_BITS-1:0]  base;
    logic [COUNT_BITS-1:0] bumped;
    logic [31:0]           now_q;
    logic [63:0]           recip_prod;
    logic [63-BKT_RECIP_SHIFT:0] quot_reg, quot_next;

    assign now_q   = item_reg.now;
    // quotient by reciprocal multiply, registered; remainder from the low bits
    assign recip_prod = 64'(now_q) * 64'(BKT_RECIP);
    assign quot_next  = recip_prod[63:BKT_RECIP_SHIFT];
    assign now_bkt    = now_q[BKT_BITS-1:0]
                        - BKT_BITS'(quot_reg[BKT_BITS-1:0] * BKT_BITS'(BUCKETS));
    assign span    = {1'b0, now_q} - {1'b0, ent_rstamp};
    assign base    = ADDR_BITS'(idx_reg) * ADDR_BITS'(BUCKETS);
    assign bumped  = (bkt_rdata == {COUNT_BITS{1'b1}}) ? bkt_rdata : bkt_rdata + 1'b1;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        idx_reg       <= idx_next;
        scan_reg      <= scan_next;
        bk_reg        <= bk_next;
        clr_cnt_reg   <= clr_cnt_next;
        clr_pos_reg   <= clr_pos_next;
        sum_reg       <= sum_next;
        tick_mode_reg <= tick_mode_next;
        out_reg       <= out_next;
        quot_reg      <= quot_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    unique case (in_data.command)
                        CMD_COUNT: state_next = S_SEARCH;
                        CMD_TICK:  state_next = S_SEARCH;
                        CMD_READ:  state_next = S_SUM;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_SEARCH:
            begin
                if (scan_reg >= used_reg)
                begin
                    if (tick_mode_reg || used_reg >= USED_BITS'(ENTRIES))
                        state_next = tick_mode_reg ? S_IDLE : S_DONE;
                    else
                        state_next = S_INIT;
                end
                else
                begin
                    state_next = S_SEARCH_WAIT;
                end
            end
            S_SEARCH_WAIT:
            begin
                if (tick_mode_reg || ent_rkey == item_reg.key)
                    state_next = S_CLEAN_RD;
                else
                    state_next = S_SEARCH;
            end
            S_CLEAN_RD:    state_next = S_CLEAN_WAIT;
            S_CLEAN_WAIT:  state_next = (clr_cnt_reg == '0) ? S_CLEAN_RD : S_CLEAN;
            S_CLEAN:
            begin
                if (clr_cnt_reg == BKT_BITS'(1))
                    state_next = tick_mode_reg ? S_SEARCH : S_BUMP_RD;
                else
                    state_next = S_CLEAN;
            end
            S_BUMP_RD:     state_next = S_BUMP_WAIT;
            S_BUMP_WAIT:   state_next = S_BUMP;
            S_BUMP:        state_next = S_DONE;
            S_INIT:
            begin
                if (bk_reg == BKT_BITS'(BUCKETS - 1))
                    state_next = S_DONE;
            end
            S_SUM:
            begin
                if (item_reg.read_index >= used_reg[IDX_BITS-1:0] || used_reg == '0)
                begin
                    if ({1'b0, item_reg.read_index} >= used_reg)
                        state_next = S_DONE;
                    else
                        state_next = S_SUM_WAIT;
                end
                else
                begin
                    state_next = S_SUM_WAIT;
                end
            end
            S_SUM_WAIT:
            begin
                if (bk_reg == BKT_BITS'(BUCKETS))
                    state_next = S_DONE;
            end
            S_DONE:        state_next = S_IDLE;
            default:       state_next = S_IDLE;
        endcase
    end

    // datapath and memory ports
    always_comb
    begin
        used_next      = used_reg;
        idx_next       = idx_reg;
        scan_next      = scan_reg;
        bk_next        = bk_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_pos_next   = clr_pos_reg;
        sum_next       = sum_reg;
        tick_mode_next = tick_mode_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;
        bkt            = '0;
        ent            = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                scan_next      = '0;
                bk_next        = '0;
                sum_next       = '0;
                tick_mode_next = (in_data.command == CMD_TICK);
                // result register is held until a new transaction starts
                if (in_valid && in_ready)
                    out_next = '0;
            end
            S_SEARCH:
            begin
                idx_next  = scan_reg[IDX_BITS-1:0];
                ent.raddr = scan_reg[IDX_BITS-1:0];
                scan_next = scan_reg + 1'b1;
                if (scan_reg >= used_reg && !tick_mode_reg)
                begin
                    if (used_reg >= USED_BITS'(ENTRIES))
                    begin
                        out_next.status = ST_FULL;
                    end
                    else
                    begin
                        idx_next  = used_reg[IDX_BITS-1:0];
                        used_next = used_reg + 1'b1;
                        bk_next   = '0;
                        out_next.status      = ST_ADDED;
                        out_next.entry_index = used_reg[IDX_BITS-1:0];
                    end
                end
            end
            S_SEARCH_WAIT:
            begin
                // decide clear span from stamp
                ent.raddr = idx_reg;
                if (!tick_mode_reg && ent_rkey == item_reg.key)
                begin
                    out_next.status      = ST_COUNTED;
                    out_next.entry_index = idx_reg;
                    scan_next            = USED_BITS'(ENTRIES);
                end
                if (span[32])
                begin
                    // stamp ahead of now: park the position so nothing is written
                    clr_cnt_next = '0;
                    clr_pos_next = BKT_BITS'(BUCKETS);
                end
                else if (span[31:0] >= 32'(BUCKETS))
                begin
                    clr_cnt_next = BKT_BITS'(BUCKETS);
                    clr_pos_next = '0;
                end
                else
                begin
                    clr_cnt_next = BKT_BITS'(span[BKT_BITS-1:0] + 1'b1);
                    // stamp mod buckets, stepped back from now mod buckets
                    clr_pos_next = (now_bkt >= span[BKT_BITS-1:0])
                        ? now_bkt - span[BKT_BITS-1:0]
                        : now_bkt + BKT_BITS'(BUCKETS) - span[BKT_BITS-1:0];
                end
            end
            S_CLEAN_RD:
            begin
                // nothing stale: skip straight on
                if (clr_cnt_reg == '0)
                    clr_cnt_next = BKT_BITS'(1);
            end
            S_CLEAN_WAIT: ;
            S_CLEAN:
            begin
                if (clr_pos_reg != BKT_BITS'(BUCKETS))
                begin
                    bkt.we    = 1'b1;
                    bkt.waddr = base + ADDR_BITS'(clr_pos_reg);
                    bkt.wdata = '0;
                end
                clr_cnt_next = clr_cnt_reg - 1'b1;
                clr_pos_next = (clr_pos_reg == BKT_BITS'(BUCKETS - 1))
                    ? '0 : clr_pos_reg + 1'b1;
                if (clr_cnt_reg == BKT_BITS'(1) && clr_pos_reg != BKT_BITS'(BUCKETS))
                begin
                    ent.we     = 1'b1;
                    ent.waddr  = idx_reg;
                    ent.wstamp = now_q + 1'b1;
                end
            end
            S_BUMP_RD:
            begin
                bkt.raddr = base + ADDR_BITS'(now_bkt);
            end
            S_BUMP_WAIT:
            begin
                bkt.raddr = base + ADDR_BITS'(now_bkt);
            end
            S_BUMP:
            begin
                bkt.we         = 1'b1;
                bkt.waddr      = base + ADDR_BITS'(now_bkt);
                bkt.wdata      = bumped;
            end
            S_INIT:
            begin
                bkt.we    = 1'b1;
                bkt.waddr = base + ADDR_BITS'(bk_reg);
                bkt.wdata = (bk_reg == now_bkt) ? COUNT_BITS'(1) : '0;
                bk_next   = bk_reg + 1'b1;
                if (bk_reg == '0)
                begin
                    ent.we      = 1'b1;
                    ent.waddr   = idx_reg;
                    ent.wkey_en = 1'b1;
                    ent.wkey    = item_reg.key;
                    ent.wstamp  = now_q + 1'b1;
                end
            end
            S_SUM:
            begin
                idx_next             = item_reg.read_index;
                out_next.entry_index = item_reg.read_index;
                out_next.status      = ST_EMPTY;
                ent.raddr            = item_reg.read_index;
                bkt.raddr            = ADDR_BITS'(item_reg.read_index) * ADDR_BITS'(BUCKETS);
                bk_next              = '0;
            end
            S_SUM_WAIT:
            begin
                // one bucket read in flight per cycle
                bkt.raddr = base + ADDR_BITS'(bk_reg + 1'b1);
                ent.raddr = idx_reg;
                if (bk_reg == '0)
                    sum_next = (TOTAL_BITS+1)'(bkt_rdata);
                else
                    sum_next = sum_reg + (TOTAL_BITS+1)'(bkt_rdata);
                bk_next = bk_reg + 1'b1;
                if (bk_reg == BKT_BITS'(BUCKETS))
                begin
                    sum_next              = sum_reg;
                    out_next.status       = ST_READ_OK;
                    out_next.key_out      = ent_rkey;
                    out_next.window_total = sum_reg[TOTAL_BITS] ? {TOTAL_BITS{1'b1}}
                                            : sum_reg[TOTAL_BITS-1:0];
                end
            end
            S_DONE:
            begin
                out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- src/windowed_event_rate_table.sv -----
// count: a hit searches the entries, clears stale buckets and bumps; a new key fills a fresh entry; full sets ST_FULL
// tick: walks the used entries one entry at a time, clearing stale buckets, no result
// read: one bucket summed per cycle through the bucket memory port
// one transaction at a time; the result register frees once taken
// rst_n asynchronously empties the table; memories hold no reset and need no clearing pass
`default_nettype none

module windowed_event_rate_table
    import wert_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_data
);

    bkt_req_t              bkt;
    ent_req_t              ent;
    logic [COUNT_BITS-1:0] bkt_rdata;
    logic [KEY_BITS-1:0]   ent_rkey;
    logic [31:0]           ent_rstamp;

    // sequencer
    wert_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .bkt        (bkt),
        .bkt_rdata  (bkt_rdata),
        .ent        (ent),
        .ent_rkey   (ent_rkey),
        .ent_rstamp (ent_rstamp)
    );

    // bucket store
    wert_bucket_ram u_bkt (
        .clk   (clk),
        .req   (bkt),
        .rdata (bkt_rdata)
    );

    // key and stamp store
    wert_entry_ram u_ent (
        .clk    (clk),
        .req    (ent),
        .rkey   (ent_rkey),
        .rstamp (ent_rstamp)
    );

endmodule

`default_nettype wire

// ----- src/wert_checker.sv -----
// ----------------------------------------------------------------------------
// wert_checker
// port-level checks of the rate table
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module wert_checker
    import wert_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_ready,
    input  wire in_item_t  in_data,
    input  wire logic      out_valid,
    input  wire logic      out_ready,
    input  wire out_item_t out_data
);

    // one transaction at a time: no new item while a result waits
    `ASSERT_IMPLY(a_no_accept_busy, clk, rst_n, out_valid, !in_ready, "accept while result pending")
    // a result stays until taken
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "result dropped")
    // status codes stay in range
    `ASSERT_IMPLY(a_status, clk, rst_n, out_valid, out_data.status <= ST_EMPTY, "bad status")
    // an accepted known command blocks the input next cycle
    `ASSERT_NEXT(a_busy_after, clk, rst_n, in_valid && in_ready && (in_data.command == CMD_COUNT || in_data.command == CMD_TICK || in_data.command == CMD_READ), !in_ready, "ready after accept")

endmodule

bind windowed_event_rate_table wert_checker u_wert_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
